### src/esc_telemetry_frame_parser_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ESC telemetry frame parser
// ---------------------------------------------------------------------------
`ifndef ESC_TELEMETRY_FRAME_PARSER_DEFINES_SVH
`define ESC_TELEMETRY_FRAME_PARSER_DEFINES_SVH

// implication checked every clock, off during reset
`define ETP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the next cycle
`define ETP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/etp_pkg.sv
// ---------------------------------------------------------------------------
// etp_pkg
// Types and constants shared by the ESC telemetry frame parser.
// ---------------------------------------------------------------------------
package etp_pkg;

	localparam int FRAME_BYTES = 10;
	localparam int MOTORS_DEF  = 4;
	localparam int QDEPTH      = 2;

	localparam logic [7:0]  CRC_POLY     = 8'h07;
	localparam logic [6:0]  RPM_SCALE    = 7'd100;
	localparam logic [31:0] TIMEOUT_RST  = 32'd1000;
	localparam logic [7:0]  POLES_RST    = 8'd14;

	localparam logic [0:0] CFG_TIMEOUT = 1'b0;
	localparam logic [0:0] CFG_POLES   = 1'b1;

	localparam logic REQ_BYTE   = 1'b0;
	localparam logic REQ_EXPECT = 1'b1;

	localparam logic [1:0] ST_PUBLISHED = 2'd0;
	localparam logic [1:0] ST_CRC_ERR   = 2'd1;
	localparam logic [1:0] ST_UNASSIGN  = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  data_byte;
		logic [2:0]  motor_sel;
		logic [31:0] now_us;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [2:0]        motor_slot;
		logic signed [7:0] temp_degc;
		logic [15:0]       volt_cv;
		logic [15:0]       curr_ca;
		logic [15:0]       used_mah;
		logic [22:0]       elec_rpm;
		logic [22:0]       mechanical_rpm;
		logic [7:0]        seen_motors;
		logic [31:0]       good_frames;
		logic [31:0]       crc_errors;
		logic [31:0]       unassigned_frames;
	} out_word_t;

	// front to back: full window plus classification
	typedef struct packed {
		logic        req_type;
		logic [2:0]  motor_sel;
		logic [31:0] now_us;
		logic        frame;      // window full after this byte
		logic [FRAME_BYTES*8-1:0] win;
	} task_word_t;

	// one byte step of CRC-8, MSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
		logic [7:0] r;
		r = c ^ d;
		for (int b = 0; b < 8; b++) begin
			r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

endpackage

### src/esc_telemetry_frame_parser.sv
// ---------------------------------------------------------------------------
// esc_telemetry_frame_parser
// CRC-8 checked ESC telemetry frame parser with expected-motor assignment.
// ---------------------------------------------------------------------------
//  channel  | handshake        | word
//  in       | in_valid/stall   | req_type, data_byte, motor_sel, now_us
//  out      | out_valid/stall  | status, decoded fields, counters
//  cfg      | cfg_we           | cfg_index, cfg_data
// Non-frame words are queued by the front and consumed by the back end from idle.
// A byte that fills the window holds the input until its frame is done: it is
// queued, started, CRC-checked over the bytes before the CRC byte, judged, divided
// serially for mechanical rpm, and loaded into the output register.
// Input stalls while a frame is in flight, a stalled result holds the back
// end, or the two-entry queue is full.
// Reset clears counters, fill count and expected motor; the window is not reset.
`include "esc_telemetry_frame_parser_defines.svh"
module esc_telemetry_frame_parser #(
	parameter int MOTORS = etp_pkg::MOTORS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  etp_pkg::in_word_t  in_data,
	input  logic               in_valid,
	output logic               in_stall,
	output etp_pkg::out_word_t out_data,
	output logic               out_valid,
	input  logic               out_stall,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	etp_pkg::task_word_t q_data;
	logic        q_valid, q_pop, frame_clear;
	logic [31:0] timeout_q;
	logic [7:0]  poles_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= etp_pkg::TIMEOUT_RST;
			poles_q   <= etp_pkg::POLES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				etp_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
				etp_pkg::CFG_POLES:   poles_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	etp_front u_front (
		.clk, .arst_n, .in_data, .in_valid, .in_stall,
		.frame_clear, .q_data, .q_valid, .q_pop
	);

	etp_back #(.MOTORS(MOTORS)) u_back (
		.clk, .arst_n, .q_data, .q_valid, .q_pop, .frame_clear,
		.timeout_us(timeout_q), .pole_count(poles_q),
		.out_data, .out_valid, .out_stall
	);

	`ETP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "output word changed while stalled")
	`ETP_ASSERT_IMP(a_pop_valid, q_pop, q_valid, "pop from empty queue")
	`ETP_ASSERT_IMP(a_status_range, out_valid, out_data.status != 2'd3, "bad status code")
endmodule

### src/etp_front.sv
// ---------------------------------------------------------------------------
// etp_front
// Accepts words, keeps the sliding byte window, queues work for the back end.
// ---------------------------------------------------------------------------
module etp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  etp_pkg::in_word_t   in_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                frame_clear,   // back end: good or unassigned frame
	output etp_pkg::task_word_t q_data,
	output logic                q_valid,
	input  logic                q_pop
);
	localparam int FB = etp_pkg::FRAME_BYTES;

	logic [7:0] win_q [FB];
	logic [3:0] fill_q;
	logic       busy_q;     // a frame is in flight; window held until its result is loaded for output

	etp_pkg::task_word_t qmem_q [etp_pkg::QDEPTH];
	logic                wr_q, rd_q;
	logic [1:0]          cnt_q;

	logic       acc;
	logic       is_byte;
	logic [3:0] fill_nx;
	logic [7:0] win_nx [FB];
	etp_pkg::task_word_t tw;

	// stall while queue full or window waiting for a frame verdict
	assign in_stall = (cnt_q == 2'(etp_pkg::QDEPTH)) || busy_q;
	assign acc      = in_valid && !in_stall;
	assign is_byte  = in_data.req_type == etp_pkg::REQ_BYTE;

	// next window contents
	always_comb begin
		for (int i = 0; i < FB; i++) win_nx[i] = win_q[i];
		fill_nx = fill_q;
		if (fill_q < 4'(FB)) begin
			win_nx[fill_q] = in_data.data_byte;
			fill_nx = fill_q + 4'd1;
		end else begin
			for (int i = 0; i < FB - 1; i++) win_nx[i] = win_q[i + 1];
			win_nx[FB - 1] = in_data.data_byte;
		end
		tw.req_type  = in_data.req_type;
		tw.motor_sel = in_data.motor_sel;
		tw.now_us    = in_data.now_us;
		tw.frame     = is_byte && (fill_nx == 4'(FB));
		for (int i = 0; i < FB; i++) tw.win[(FB-1-i)*8 +: 8] = win_nx[i];
	end

	// window and fill state
	always_ff @(posedge clk) begin
		if (acc && is_byte) for (int i = 0; i < FB; i++) win_q[i] <= win_nx[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			busy_q <= 1'b0;
		end else begin
			if (frame_clear) fill_q <= '0;
			else if (acc && is_byte) fill_q <= fill_nx;
			if (acc && tw.frame) busy_q <= 1'b1;
			else if (q_pop && q_data.frame) busy_q <= 1'b0;
		end
	end

	// work queue
	always_ff @(posedge clk) begin
		if (acc) qmem_q[wr_q] <= tw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (acc) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(q_pop);
		end
	end

	assign q_valid = cnt_q != 2'd0;
	assign q_data  = qmem_q[rd_q];
endmodule

### src/etp_back.sv
// ---------------------------------------------------------------------------
// etp_back
// Runs CRC, timeout test, decode and serial divide; keeps counters.
// ---------------------------------------------------------------------------
module etp_back #(
	parameter int MOTORS = etp_pkg::MOTORS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  etp_pkg::task_word_t q_data,
	input  logic                q_valid,
	output logic                q_pop,
	output logic                frame_clear,
	input  logic [31:0]         timeout_us,
	input  logic [7:0]          pole_count,
	output etp_pkg::out_word_t  out_data,
	output logic                out_valid,
	input  logic                out_stall
);
	localparam int FB = etp_pkg::FRAME_BYTES;
	localparam int SW = $clog2(MOTORS + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CRC  = 5'b00010,
		S_EVAL = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t      st_q;
	logic [3:0]  idx_q;
	logic [7:0]  crc_q;
	logic [SW-1:0] exp_q;
	logic [31:0] since_q;
	logic [7:0]  seen_q;
	logic [31:0] good_q, crcc_q, unas_q;
	logic [22:0] rem_q, quo_q;
	logic [6:0]  pairs_q;
	logic [4:0]  dcnt_q;
	etp_pkg::out_word_t res_q;
	etp_pkg::out_word_t out_q;   // output word, held while stalled
	logic        ovalid_q;

	logic [7:0]  byte_at;
	logic [31:0] age;
	logic        active;
	logic [23:0] trial;
	logic [22:0] erpm_w;

	assign byte_at = q_data.win[(FB-1-int'(idx_q))*8 +: 8];
	assign age     = q_data.now_us - since_q;
	assign active  = (exp_q < SW'(MOTORS)) && (age <= timeout_us);
	// frame bytes 7..8, big-endian, times 100
	assign erpm_w  = {7'd0, q_data.win[23:8]} * {16'd0, etp_pkg::RPM_SCALE};
	assign trial   = {rem_q, quo_q[22]} - {17'd0, pairs_q};

	assign q_pop       = (st_q == S_IDLE && q_valid && !q_data.frame)
	                  || (st_q == S_OUT && !ovalid_q);
	assign frame_clear = st_q == S_OUT && !ovalid_q && res_q.status != etp_pkg::ST_CRC_ERR;
	assign out_data    = out_q;
	assign out_valid   = ovalid_q;

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				idx_q <= '0;
				crc_q <= '0;
			end
			S_CRC: begin
				crc_q <= etp_pkg::crc8_byte(crc_q, byte_at);
				idx_q <= idx_q + 4'd1;
			end
			S_EVAL: begin
				res_q <= '0;
				pairs_q <= pole_count[7:1];
				quo_q <= erpm_w;
				rem_q <= '0;
				dcnt_q <= '0;
				if (crc_q != q_data.win[7:0]) begin
					res_q.status <= etp_pkg::ST_CRC_ERR;
				end else if (!active) begin
					res_q.status <= etp_pkg::ST_UNASSIGN;
				end else begin
					res_q.status <= etp_pkg::ST_PUBLISHED;
					res_q.motor_slot <= 3'(exp_q);
					res_q.temp_degc <= q_data.win[FB*8-1 -: 8];
					res_q.volt_cv <= q_data.win[FB*8-9 -: 16];
					res_q.curr_ca <= q_data.win[FB*8-25 -: 16];
					res_q.used_mah <= q_data.win[FB*8-41 -: 16];
					res_q.elec_rpm <= erpm_w;
				end
			end
			S_DIV: begin
				// restoring divide, one quotient bit per cycle
				if (!trial[23]) begin
					rem_q <= trial[22:0];
					quo_q <= {quo_q[21:0], 1'b1};
				end else begin
					rem_q <= {rem_q[21:0], quo_q[22]};
					quo_q <= {quo_q[21:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 5'd1;
				if (dcnt_q == 5'd22) begin
					res_q.seen_motors <= seen_q;
					res_q.good_frames <= good_q;
					res_q.crc_errors <= crcc_q;
					res_q.unassigned_frames <= unas_q;
					if (res_q.status == etp_pkg::ST_PUBLISHED && pairs_q != 7'd0)
						res_q.mechanical_rpm <= !trial[23] ? {quo_q[21:0], 1'b1}
						                                   : {quo_q[21:0], 1'b0};
				end
			end
			S_OUT: begin
				if (!ovalid_q) out_q <= res_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			exp_q    <= SW'(MOTORS);
			since_q  <= '0;
			seen_q   <= '0;
			good_q   <= '0;
			crcc_q   <= '0;
			unas_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (q_valid && q_data.frame) st_q <= S_CRC;
					else if (q_valid && q_data.req_type == etp_pkg::REQ_EXPECT
					         && {1'b0, q_data.motor_sel} < 4'(MOTORS)) begin
						exp_q   <= SW'(q_data.motor_sel);
						since_q <= q_data.now_us;
					end
				end
				S_CRC: if (idx_q == 4'(FB - 2)) st_q <= S_EVAL;
				S_EVAL: begin
					st_q <= S_DIV;
					if (crc_q != q_data.win[7:0]) crcc_q <= crcc_q + 32'd1;
					else begin
						if (!active) unas_q <= unas_q + 32'd1;
						else begin
							good_q <= good_q + 32'd1;
							seen_q <= seen_q | (8'd1 << exp_q);
						end
						exp_q <= SW'(MOTORS);
					end
				end
				S_DIV: if (dcnt_q == 5'd22) st_q <= S_OUT;
				S_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### tb/esc_telemetry_frame_checker.sv
// ---------------------------------------------------------------------------
// esc_telemetry_frame_checker
// Watches the input and output channels of the telemetry frame parser,
// predicts each result word from the accepted input words and compares.
// ---------------------------------------------------------------------------
module esc_telemetry_frame_checker #(
	parameter int MOTORS = etp_pkg::MOTORS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  etp_pkg::in_word_t  in_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  etp_pkg::out_word_t out_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 fail_count,
	output int                 pending_frames,
	output int                 published_seen,
	output int                 crc_seen,
	output int                 unassigned_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = etp_pkg::FRAME_BYTES;

	// model state
	logic [31:0] timeout_us;
	logic [7:0]  pole_count;
	logic [7:0]  win [FB];
	int          fill;
	int          exp_motor;
	logic [31:0] exp_since;
	logic [7:0]  seen;
	logic [31:0] n_good, n_crc, n_unas;

	etp_pkg::out_word_t frame_results [$];

	function automatic logic [7:0] frame_crc(input logic [7:0] w [FB]);
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < FB - 1; i++) begin
			c = c ^ w[i];
			for (int b = 0; b < 8; b++) begin
				c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
			end
		end
		return c;
	endfunction

	// advance the model by one input word
	task automatic parse_word(input etp_pkg::in_word_t w);
		etp_pkg::out_word_t r;
		logic [31:0] erpm, pairs;
		if (w.req_type == etp_pkg::REQ_EXPECT) begin
			if (w.motor_sel < MOTORS) begin
				exp_motor = w.motor_sel;
				exp_since = w.now_us;
			end
			return;
		end
		if (fill < FB) begin
			win[fill] = w.data_byte;
			fill++;
		end else begin
			for (int i = 0; i < FB - 1; i++) win[i] = win[i+1];
			win[FB-1] = w.data_byte;
		end
		if (fill != FB) return;
		r = '0;
		if (frame_crc(win) != win[FB-1]) begin
			n_crc++;
			r.status = etp_pkg::ST_CRC_ERR;
		end else begin
			if (exp_motor < MOTORS && (w.now_us - exp_since) <= timeout_us) begin
				pairs = {24'd0, pole_count} / 32'd2;
				erpm = {16'd0, win[7], win[8]} * 32'd100;
				r.status = etp_pkg::ST_PUBLISHED;
				r.motor_slot = 3'(exp_motor);
				r.temp_degc = win[0];
				r.volt_cv = {win[1], win[2]};
				r.curr_ca = {win[3], win[4]};
				r.used_mah = {win[5], win[6]};
				r.elec_rpm = erpm[22:0];
				r.mechanical_rpm = (pairs == 0) ? 23'd0 : 23'(erpm / pairs);
				seen = seen | (8'd1 << exp_motor);
				n_good++;
			end else begin
				n_unas++;
				r.status = etp_pkg::ST_UNASSIGN;
			end
			exp_motor = MOTORS;
			fill = 0;
		end
		r.seen_motors = seen;
		r.good_frames = n_good;
		r.crc_errors = n_crc;
		r.unassigned_frames = n_unas;
		frame_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		etp_pkg::out_word_t e;
		if (!arst_n) begin
			timeout_us = etp_pkg::TIMEOUT_RST;
			pole_count = etp_pkg::POLES_RST;
			fill = 0;
			exp_motor = MOTORS;
			exp_since = '0;
			seen = '0;
			n_good = '0;
			n_crc = '0;
			n_unas = '0;
			frame_results.delete();
			fail_count = 0;
			published_seen = 0;
			crc_seen = 0;
			unassigned_seen = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == etp_pkg::CFG_TIMEOUT) timeout_us = cfg_data;
				else if (cfg_index == etp_pkg::CFG_POLES) pole_count = cfg_data[7:0];
			end
			if (in_valid && !in_stall) parse_word(in_data);
			// compare the output word with the oldest prediction
			if (out_valid && !out_stall) begin
				if (frame_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result word, expected none, actual %p",
						$time, out_data);
				end else begin
					e = frame_results.pop_front();
					if (out_data !== e) begin
						fail_count++;
						$display("%0t: result mismatch\n  expected %p\n  actual   %p",
							$time, e, out_data);
					end
					case (e.status)
						etp_pkg::ST_PUBLISHED: published_seen++;
						etp_pkg::ST_CRC_ERR:   crc_seen++;
						default:               unassigned_seen++;
					endcase
				end
			end
		end
		pending_frames = frame_results.size();
	end
endmodule

### tb/tb_esc_telemetry_frame_parser.sv
// ---------------------------------------------------------------------------
// tb_esc_telemetry_frame_parser
// Drives telemetry bytes and expect events into the frame parser: directed
// frames first, then random well-formed frames mixed with noise, under
// bursty input and random output stalls. A checker module does the scoring.
// ---------------------------------------------------------------------------
module tb_esc_telemetry_frame_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MOTORS = etp_pkg::MOTORS_DEF;

	logic       clk, arst_n;
	etp_pkg::in_word_t  in_data;
	logic       in_valid, in_stall;
	etp_pkg::out_word_t out_data;
	logic       out_valid, out_stall;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [31:0] cfg_data;
	int fail_count, pending_frames, published_seen, crc_seen, unassigned_seen;
	int words_sent;
	logic [31:0] clock_us;
	logic hold_off;
	int burst_left;

	esc_telemetry_frame_parser #(.MOTORS(MOTORS)) u_dut (.*);

	esc_telemetry_frame_checker #(.MOTORS(MOTORS)) u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("tb_esc_telemetry_frame_parser failed");
		$finish;
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1;
				repeat (400) @(negedge clk);
				out_stall <= 0;
				hold_off = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall <= ($urandom_range(0, 2) != 0);
			end
		end
	end

	// send one word; gaps come between random-length bursts
	task automatic send_word(input etp_pkg::in_word_t w);
		if (burst_left == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(0, 40)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		etp_pkg::in_word_t w;
		w = '0;
		w.req_type = etp_pkg::REQ_BYTE;
		w.data_byte = b;
		w.motor_sel = 3'($urandom);
		clock_us = clock_us + $urandom_range(0, 90);
		w.now_us = clock_us;
		send_word(w);
	endtask

	task automatic send_expect(input logic [2:0] m);
		etp_pkg::in_word_t w;
		w = '0;
		w.req_type = etp_pkg::REQ_EXPECT;
		w.motor_sel = m;
		w.data_byte = 8'($urandom);
		w.now_us = clock_us;
		send_word(w);
	endtask

	// nine payload bytes plus CRC; corrupt flips one bit of the CRC
	task automatic send_frame(input logic [7:0] p [9], input bit corrupt);
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < 9; i++) begin
			c = crc8_ref(c, p[i]);
			send_byte(p[i]);
		end
		if (corrupt) c = c ^ (8'h01 << $urandom_range(0, 7));
		send_byte(c);
	endtask

	function automatic logic [7:0] crc8_ref(input logic [7:0] c, input logic [7:0] d);
		logic [7:0] r;
		r = c ^ d;
		for (int b = 0; b < 8; b++) r = r[7] ? ((r << 1) ^ 8'h07) : (r << 1);
		return r;
	endfunction

	task automatic random_frame(input logic [7:0] fill_val, input bit use_fill);
		logic [7:0] p [9];
		for (int i = 0; i < 9; i++) p[i] = use_fill ? fill_val : 8'($urandom);
		send_frame(p, 0);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending_frames != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		logic [7:0] p [9];
		int phase;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = etp_pkg::CFG_TIMEOUT;
		cfg_data = '0;
		arst_n = 0;
		hold_off = 0;
		burst_left = 0;
		words_sent = 0;
		clock_us = 32'hFFFF_F000;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset settings, extremes, unassigned, crc error, slides
		send_expect(3'd0);
		random_frame(8'h00, 1);
		send_expect(3'd3);
		random_frame(8'hFF, 1);
		random_frame(8'h80, 1);
		send_expect(3'd7);
		send_expect(3'(MOTORS));
		random_frame(8'h7F, 1);
		for (int i = 0; i < 9; i++) p[i] = 8'($urandom);
		send_expect(3'd1);
		send_frame(p, 1);
		send_byte(8'h55);
		send_byte(8'hAA);
		drain();
		// expired expect: timeout passes before the frame completes
		write_reg(etp_pkg::CFG_TIMEOUT, 32'd1);
		write_reg(etp_pkg::CFG_POLES, 32'd2);
		send_expect(3'd2);
		random_frame(8'h12, 0);
		send_expect(3'd2);
		random_frame(8'hFF, 1);
		drain();
		write_reg(etp_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(etp_pkg::CFG_POLES, 32'd255);
		send_expect(3'd3);
		random_frame(8'hFF, 1);
		drain();

		// random phases with varying settings
		phase = 0;
		while (words_sent < 1450) begin
			if ((words_sent / 300) != phase) begin
				phase = words_sent / 300;
				drain();
				write_reg(etp_pkg::CFG_TIMEOUT,
					(phase % 3 == 0) ? 32'd1 : 32'($urandom_range(50, 2000)));
				write_reg(etp_pkg::CFG_POLES,
					(phase % 2 == 0) ? 32'd3 : 32'($urandom_range(2, 255)));
				// long receiver hold-off while input keeps coming
				if (phase == 1) hold_off = 1;
			end
			case ($urandom_range(0, 9))
				0: send_byte(8'($urandom));
				1: send_expect(3'($urandom));
				2: begin
					for (int i = 0; i < 9; i++) p[i] = 8'($urandom);
					send_frame(p, 1);
				end
				default: begin
					if ($urandom_range(0, 3) != 0)
						send_expect(3'($urandom_range(0, MOTORS - 1)));
					random_frame(8'h00, 0);
				end
			endcase
		end
		drain();

		$display("covered %0d words: %0d published, %0d crc errors, %0d unassigned",
			words_sent, published_seen, crc_seen, unassigned_seen);
		if (fail_count == 0) begin
			$display("tb_esc_telemetry_frame_parser passed");
		end else begin
			$display("tb_esc_telemetry_frame_parser failed");
		end
		$finish;
	end
endmodule
